// ----- rtl/pwg_pkg.sv -----
// Shared types and constants of the PWM waveform pattern generator.
package pwg_pkg;

	// Register field widths
	localparam int SHAPE_W  = 2;
	localparam int GAIN_W   = 17;
	localparam int LEVEL_W  = 16;
	localparam int LG_W     = 4;
	localparam int HOLD_W   = 8;
	localparam int SAMPLE_W = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FORCE_ENABLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FORCED_LEVEL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOG2   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT     = 3'd6;

	// Waveform shapes
	localparam logic [SHAPE_W-1:0] WAVE_SINE     = 2'd0;
	localparam logic [SHAPE_W-1:0] WAVE_TRIANGLE = 2'd1;
	localparam logic [SHAPE_W-1:0] WAVE_SQUARE   = 2'd2;
	localparam logic [SHAPE_W-1:0] WAVE_SAWTOOTH = 2'd3;

	// Reset values
	localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;
	localparam logic [LG_W-1:0]   LG_RESET   = 4'd8;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'hFF;

	// Q30 fixed point constants for the sine table build
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

	typedef struct packed {
		logic [SHAPE_W-1:0] wave_shape;
		logic [GAIN_W-1:0]  amplitude_gain;
		logic [LEVEL_W-1:0] level_offset;
		logic               force_enable;
		logic [LEVEL_W-1:0] forced_level;
		logic [LG_W-1:0]    pattern_log2;
		logic [HOLD_W-1:0]  hold_count;
	} cfg_t;

endpackage

// ----- rtl/pwg_in_if.sv -----
// Tick request channel: one beat per PWM period.
interface pwg_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// ----- rtl/pwg_out_if.sv -----
// Duty value result channel.
interface pwg_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] duty_value;
	logic        pattern_start;

	modport source (output valid, output duty_value, output pattern_start, input ready);
	modport sink (input valid, input duty_value, input pattern_start, output ready);
endinterface

// ----- rtl/pwm_waveform_pattern_generator.sv -----
// PWM waveform pattern generator: one duty value per period tick from a lookup pattern.
//
// Each beat on req is one PWM period tick and yields exactly one beat on rsp, via the stage 1
// and result registers. A new tick is accepted every cycle unless rsp stalls; the only loop is the
// entry index and hold counter update, done in the accept cycle. Stage 1 registers the
// entry index and the sine table word (the table is a constant array read through a
// registered port); stage 2 forms the shape sample, the 8x17 gain product, the offset
// add and the forced-level select into the result register. The table holds one sine
// period generated at elaboration. Configuration writes are meant for idle periods.
module pwm_waveform_pattern_generator #(
	parameter int SINE_ROM_DEPTH   = 256,
	parameter int SINE_SAMPLE_BITS = 12,
	parameter int MAX_PATTERN_LOG2 = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pwg_in_if.sink                        req,
	pwg_out_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [pwg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwg_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = MAX_PATTERN_LOG2;
	localparam int AW = $clog2(SINE_ROM_DEPTH);
	localparam int PW = IW + $clog2(SINE_ROM_DEPTH + 1);
	localparam int TW = IW + 1;
	localparam int NW = TW + pwg_pkg::SAMPLE_W;
	localparam int MW = pwg_pkg::SAMPLE_W + pwg_pkg::GAIN_W;

	typedef logic [SINE_SAMPLE_BITS-1:0] rom_t [SINE_ROM_DEPTH];

	// sin(a), a in [0, pi/2], Q30 in and out, truncating Horner series
	function automatic logic [63:0] sin_q30(input logic [63:0] a);
		logic [63:0] a2;
		logic [63:0] b;
		a2 = (a * a) >> 30;
		b = pwg_pkg::Q30_ONE;
		b = pwg_pkg::Q30_ONE - (((a2 * b) >> 30) / 64'd110);
		b = pwg_pkg::Q30_ONE - (((a2 * b) >> 30) / 64'd72);
		b = pwg_pkg::Q30_ONE - (((a2 * b) >> 30) / 64'd42);
		b = pwg_pkg::Q30_ONE - (((a2 * b) >> 30) / 64'd20);
		b = pwg_pkg::Q30_ONE - (((a2 * b) >> 30) / 64'd6);
		b = (a * b) >> 30;
		return (b > pwg_pkg::Q30_ONE) ? pwg_pkg::Q30_ONE : b;
	endfunction

	// One sine period, offset to mid scale, rounded to SINE_SAMPLE_BITS
	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] full;
		logic [63:0] t;
		logic [63:0] quad;
		logic [63:0] rem;
		logic [63:0] s;
		logic [63:0] u;
		full = (64'd1 << SINE_SAMPLE_BITS) - 64'd1;
		for (int k = 0; k < SINE_ROM_DEPTH; k++) begin
			t = 64'(4 * k);
			quad = t / SINE_ROM_DEPTH;
			rem = t % SINE_ROM_DEPTH;
			if (quad[0])
				rem = 64'(SINE_ROM_DEPTH) - rem;
			s = sin_q30((pwg_pkg::Q30_HALF_PI * rem) / SINE_ROM_DEPTH);
			u = (quad >= 64'd2) ? pwg_pkg::Q30_ONE - s : pwg_pkg::Q30_ONE + s;
			rom[k] = SINE_SAMPLE_BITS'((full * u + pwg_pkg::Q30_ONE) >> 31);
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Configuration registers
	pwg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave_shape     <= pwg_pkg::WAVE_SINE;
			cfg_q.amplitude_gain <= pwg_pkg::GAIN_UNITY;
			cfg_q.level_offset   <= '0;
			cfg_q.force_enable   <= 1'b0;
			cfg_q.forced_level   <= '0;
			cfg_q.pattern_log2   <= pwg_pkg::LG_RESET;
			cfg_q.hold_count     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pwg_pkg::REG_WAVE_SHAPE:
					cfg_q.wave_shape <= cfg_data[pwg_pkg::SHAPE_W-1:0];
				pwg_pkg::REG_AMPLITUDE_GAIN:
					cfg_q.amplitude_gain <= cfg_data[pwg_pkg::GAIN_W-1:0];
				pwg_pkg::REG_LEVEL_OFFSET:
					cfg_q.level_offset <= cfg_data[pwg_pkg::LEVEL_W-1:0];
				pwg_pkg::REG_FORCE_ENABLE:
					cfg_q.force_enable <= cfg_data[0];
				pwg_pkg::REG_FORCED_LEVEL:
					cfg_q.forced_level <= cfg_data[pwg_pkg::LEVEL_W-1:0];
				pwg_pkg::REG_PATTERN_LOG2:
					cfg_q.pattern_log2 <= cfg_data[pwg_pkg::LG_W-1:0];
				pwg_pkg::REG_HOLD_COUNT:
					cfg_q.hold_count <= cfg_data[pwg_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake and stage control
	logic valid_s1;
	logic rsp_valid_q;
	logic out_free;
	logic load_s1;
	logic move_s2;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || out_free;
	assign load_s1   = req.valid && req.ready;
	assign move_s2   = valid_s1 && out_free;

	// Effective pattern length, saturated to 1..MAX_PATTERN_LOG2
	logic [pwg_pkg::LG_W-1:0] lg_eff;
	logic [IW-1:0]            idx_mask;

	always_comb begin
		if (cfg_q.pattern_log2 == '0)
			lg_eff = pwg_pkg::LG_W'(1);
		else if (cfg_q.pattern_log2 > pwg_pkg::LG_W'(MAX_PATTERN_LOG2))
			lg_eff = pwg_pkg::LG_W'(MAX_PATTERN_LOG2);
		else
			lg_eff = cfg_q.pattern_log2;
		for (int b = 0; b < IW; b++)
			idx_mask[b] = (b < int'(lg_eff));
	end

	// Index and hold counter sequencing
	logic [IW-1:0]             entry_index_q;
	logic [pwg_pkg::HOLD_W-1:0] hold_counter_q;
	logic [IW-1:0]             cur_index;
	logic [pwg_pkg::HOLD_W-1:0] cur_hold;
	logic                      tick_start;

	assign cur_index  = (req.restart ? '0 : entry_index_q) & idx_mask;
	assign cur_hold   = req.restart ? '0 : hold_counter_q;
	assign tick_start = (cur_index == '0) && (cur_hold == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_index_q  <= '0;
			hold_counter_q <= '0;
		end else if (load_s1) begin
			if (cur_hold >= cfg_q.hold_count) begin
				hold_counter_q <= '0;
				entry_index_q  <= (cur_index + IW'(1)) & idx_mask;
			end else begin
				hold_counter_q <= cur_hold + pwg_pkg::HOLD_W'(1);
				entry_index_q  <= cur_index;
			end
		end
	end

	// Sine table address: (index * depth) >> L
	logic [PW-1:0] addr_full;
	logic [AW-1:0] rom_addr;

	assign addr_full = (PW'(cur_index) * PW'(SINE_ROM_DEPTH)) >> lg_eff;
	assign rom_addr  = addr_full[AW-1:0];

	// Stage 1 registers
	logic [IW-1:0]               index_s1;
	logic [pwg_pkg::LG_W-1:0]    lg_s1;
	logic                        start_s1;
	logic [SINE_SAMPLE_BITS-1:0] rom_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load_s1)
			valid_s1 <= 1'b1;
		else if (move_s2)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			index_s1 <= cur_index;
			lg_s1    <= lg_eff;
			start_s1 <= tick_start;
			rom_s1   <= SINE_ROM[rom_addr];
		end
	end

	// Shape sample
	logic                         upper_half;
	logic [TW-1:0]                span;
	logic [TW-1:0]                tri_base;
	logic [NW-1:0]                tri_full;
	logic [NW-1:0]                saw_full;
	logic [pwg_pkg::SAMPLE_W-1:0] sample;

	always_comb begin
		upper_half = (index_s1 >> (lg_s1 - pwg_pkg::LG_W'(1))) != '0;
		span       = (TW'(1) << lg_s1) - TW'(index_s1);
		tri_base   = upper_half ? span : TW'(index_s1);
		tri_full   = (NW'(pwg_pkg::SAMPLE_MAX) * NW'(tri_base)) >> (lg_s1 - pwg_pkg::LG_W'(1));
		saw_full   = (NW'(pwg_pkg::SAMPLE_MAX) * NW'(index_s1)) >> lg_s1;
		case (cfg_q.wave_shape)
			pwg_pkg::WAVE_SINE:     sample = rom_s1[SINE_SAMPLE_BITS-1 -: pwg_pkg::SAMPLE_W];
			pwg_pkg::WAVE_TRIANGLE: sample = tri_full[pwg_pkg::SAMPLE_W-1:0];
			pwg_pkg::WAVE_SQUARE:   sample = upper_half ? pwg_pkg::SAMPLE_MAX : '0;
			default:                sample = saw_full[pwg_pkg::SAMPLE_W-1:0];
		endcase
	end

	// Gain, offset and forced level
	logic [MW-1:0]               scaled_full;
	logic [pwg_pkg::LEVEL_W-1:0] wave_duty;
	logic [pwg_pkg::LEVEL_W-1:0] duty_next;

	assign scaled_full = MW'(sample) * MW'(cfg_q.amplitude_gain);
	assign wave_duty   = pwg_pkg::LEVEL_W'(scaled_full[MW-1:16]) + cfg_q.level_offset;
	assign duty_next   = cfg_q.force_enable ? cfg_q.forced_level : wave_duty;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (move_s2)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			rsp.duty_value    <= duty_next;
			rsp.pattern_start <= start_s1;
		end
	end

	assign rsp.valid = rsp_valid_q;

`ifndef SYNTHESIS
	// An accepted tick always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted tick did not reach stage 1");

	// A stalled result keeps the stage 1 beat in place
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && !rsp.ready |=> valid_s1 && $stable(index_s1))
		else $error("stage 1 beat lost under backpressure");

	// A restart tick is the first tick of entry zero
	a_restart_marks_start: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.restart |=> start_s1 && index_s1 == '0)
		else $error("restart tick not flagged as pattern start");
`endif

endmodule
